>>> rtl/core/tpq_pkg.sv
`default_nettype none

package tpq_pkg;

  localparam int KEY_W = 30;
  localparam int REC_W = 16;
  localparam int OCC_W = 5;

  // Operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_INS_REG  = 2'd0,
    FUNC_INS_CRIT = 2'd1,
    FUNC_REM_HEAD = 2'd2,
    FUNC_CANCEL   = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [KEY_W-1:0]  key;
    logic [REC_W-1:0]  record;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [KEY_W-1:0]  out_key;
    logic [REC_W-1:0]  out_record;
    logic              out_critical;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  // One stored queue entry; the class follows from the position
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [REC_W-1:0]  record;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/tpq_ram.sv
`default_nettype none

module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/two_class_priority_queue.sv
`default_nettype none

// Channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------
// req      | in        | req_valid/req_ready  | tpq_pkg::req_t (func,key,record)
// rsp      | out       | rsp_valid/rsp_ready  | tpq_pkg::rsp_t (ok,key,record,class,occ)
//
// One operation at a time, req_ready high only while idle. A regular insert, a full
// insert, an all-critical insert or a remove/cancel on an empty queue finishes in
// dispatch. A critical insert shifts each regular entry up one slot first; a remove
// or a cancel scans keys from the head and, on a hit, shifts the later entries down.
// The entry RAM has one write port and one registered read port, and each shift
// step reads an entry (S_UP_RD, S_DN_RD) and then writes it (S_UP_WR, S_DN_WR).
// Synchronous reset empties the queue, not the RAM; while a finished result waits
// on rsp_ready, req_ready stays low.
module two_class_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tpq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tpq_pkg::rsp_t      rsp
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_UP_RD = 9'b000000100,
    S_UP_WR = 9'b000001000,
    S_INS   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_CMP   = 9'b001000000,
    S_DN_RD = 9'b010000000,
    S_DN_WR = 9'b100000000
  } state_t;

  state_t              state;
  logic                done;
  tpq_pkg::req_t       cur;
  tpq_pkg::rsp_t       res;
  tpq_pkg::rsp_t       rsp_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    crit;
  logic [CNT_W-1:0]    ptr;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  tpq_pkg::entry_t     ram_wdata;
  tpq_pkg::entry_t     ram_rdata;
  tpq_pkg::entry_t     new_entry;
  logic                hit;

  assign req_ready = (state == S_IDLE) && !done;
  assign new_entry = '{key: cur.key, record: cur.record};
  assign hit       = (cur.func == tpq_pkg::FUNC_REM_HEAD) || (ram_rdata.key == cur.key);

  tpq_ram #(
    .WIDTH ($bits(tpq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Select the single RAM write of this cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = new_entry;
    case (state)
      S_DISP: begin
        if (count != FULL) begin
          if (cur.func == tpq_pkg::FUNC_INS_REG) begin
            ram_we = 1'b1;
          end else if (cur.func == tpq_pkg::FUNC_INS_CRIT && crit == count) begin
            ram_we = 1'b1;
          end
        end
      end
      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(ptr + ONE);
        ram_wdata = ram_rdata;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = crit[IDX_W-1:0];
      end
      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(ptr - ONE);
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer: dispatch, shift entries one at a time, scan keys
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      crit  <= '0;
      ptr   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (done) begin
            // hold until the result register is free
            if (!rsp_valid || rsp_ready) begin
              done <= 1'b0;
            end
          end else if (req_valid) begin
            cur   <= req;
            res   <= '0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          state <= S_IDLE;
          done  <= 1'b1;
          case (cur.func)
            tpq_pkg::FUNC_INS_REG: begin
              if (count != FULL) begin
                count  <= count + ONE;
                res.ok <= 1'b1;
              end
            end
            tpq_pkg::FUNC_INS_CRIT: begin
              if (count != FULL) begin
                if (crit == count) begin
                  count  <= count + ONE;
                  crit   <= crit + ONE;
                  res.ok <= 1'b1;
                end else begin
                  ptr   <= count - ONE;
                  state <= S_UP_RD;
                  done  <= 1'b0;
                end
              end
            end
            default: begin
              if (count != '0) begin
                ptr   <= '0;
                state <= S_SCAN;
                done  <= 1'b0;
              end
            end
          endcase
        end
        S_UP_RD: begin
          state <= S_UP_WR;
        end
        S_UP_WR: begin
          if (ptr == crit) begin
            state <= S_INS;
          end else begin
            ptr   <= ptr - ONE;
            state <= S_UP_RD;
          end
        end
        S_INS: begin
          count  <= count + ONE;
          crit   <= crit + ONE;
          res.ok <= 1'b1;
          state  <= S_IDLE;
          done   <= 1'b1;
        end
        S_SCAN: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            res.ok           <= 1'b1;
            res.out_key      <= ram_rdata.key;
            res.out_record   <= ram_rdata.record;
            res.out_critical <= (ptr < crit);
            if (ptr < crit) begin
              crit <= crit - ONE;
            end
            ptr   <= ptr + ONE;
            state <= S_DN_RD;
          end else if ((ptr + ONE) == count) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            ptr   <= ptr + ONE;
            state <= S_SCAN;
          end
        end
        S_DN_RD: begin
          if (ptr == count) begin
            count <= count - ONE;
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          ptr   <= ptr + ONE;
          state <= S_DN_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Attach the occupancy to the finished result
  always_comb begin
    rsp_next           = res;
    rsp_next.occupancy = tpq_pkg::OCC_W'(count);
  end

  // Output register: load the finished result when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (done && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (done && (!rsp_valid || rsp_ready)) begin
      rsp <= rsp_next;
    end
  end

  // Critical segment never exceeds the occupancy
  a_crit_le_count: assert property (@(posedge clk) disable iff (rst)
    crit <= count)
    else $error("critical count above occupancy");

  // Occupancy never exceeds the depth
  a_count_le_depth: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("occupancy above depth");

  // An accepted request always goes to dispatch
  a_accept_disp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_DISP))
    else $error("request accepted without dispatch");

  // A failed insert leaves the occupancy unchanged
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP && count == FULL &&
     (cur.func == tpq_pkg::FUNC_INS_REG || cur.func == tpq_pkg::FUNC_INS_CRIT))
    |=> (count == FULL && !res.ok))
    else $error("insert into full queue changed state");

  // A finished result only ever waits in idle
  a_idle_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result pending outside idle");

endmodule

`default_nettype wire
